>>> src/mfm_even_odd_track_deframer_macros.svh
// Assertion macros for the MFM even/odd track deframer.
// Included by the top level; no other dependencies.
`ifndef MFM_EVEN_ODD_TRACK_DEFRAMER_MACROS_SVH
`define MFM_EVEN_ODD_TRACK_DEFRAMER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define MFM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mfm deframer: same-cycle check failed");

// next-cycle implication, disabled while in reset
`define MFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mfm deframer: next-cycle check failed");

`endif

>>> src/mfm_eo_pkg.sv
// Shared types, constants and the even/odd decode function for the MFM deframer.
// No dependencies.
package mfm_eo_pkg;

  localparam int MAX_WORDS_DEFAULT = 4096;

  localparam int WORD_W = 16;
  localparam int WCNT_CFG_W = 12;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [WORD_W-1:0] SYNC_RESET = 16'h4142;
  localparam logic [WCNT_CFG_W-1:0] WCNT_RESET = 12'hc57;
  localparam logic [WORD_W-1:0] DATA_MASK = 16'h5555;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PATTERN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_WORD_COUNT = 1'b1;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] data_word;
    logic              last_word;
    logic              checksum_ok;
  } res_t;

  // first half carries the odd (upper) data bits, second half the even bits
  function automatic logic [WORD_W-1:0] decode_even_odd(input logic [2*WORD_W-1:0] raw);
    decode_even_odd = ((raw[2*WORD_W-1:WORD_W] & DATA_MASK) << 1)
                    | (raw[WORD_W-1:0] & DATA_MASK);
  endfunction

endpackage

>>> src/mfm_eo_core.sv
// Sync hunt, bit/word counting, even/odd decode and word sum for the MFM deframer.
// Depends on mfm_eo_pkg.
module mfm_eo_core #(
  parameter int MAX_WORDS = mfm_eo_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [mfm_eo_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mfm_eo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                                bit_accept,
  input  logic                                raw_bit,
  output mfm_eo_pkg::res_t                    res
);

  localparam int WCW = (MAX_WORDS > 2) ? $clog2(MAX_WORDS) : 1;
  localparam int CW = (WCW > mfm_eo_pkg::WCNT_CFG_W) ? WCW : mfm_eo_pkg::WCNT_CFG_W;
  localparam logic [CW-1:0] WORD_CAP = CW'(MAX_WORDS - 1);

  logic [mfm_eo_pkg::WORD_W-1:0]     sync_r;
  logic [mfm_eo_pkg::WCNT_CFG_W-1:0] dwc_r;

  logic [2*mfm_eo_pkg::WORD_W-1:0] shift_r;
  logic [2*mfm_eo_pkg::WORD_W-1:0] shift_nxt;
  logic                            collecting_r;
  logic [4:0]                      bit_cnt_r;
  logic [4:0]                      bit_cnt_nxt;
  logic [WCW-1:0]                  word_cnt_r;
  logic [mfm_eo_pkg::WORD_W-1:0]   sum_r;

  logic [mfm_eo_pkg::WORD_W-1:0] word;
  logic [CW-1:0]                 dwc_ext;
  logic [CW-1:0]                 limit;
  logic                          more_data;
  logic                          word_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r <= mfm_eo_pkg::SYNC_RESET;
      dwc_r  <= mfm_eo_pkg::WCNT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        mfm_eo_pkg::CFG_SYNC_PATTERN:    sync_r <= cfg_wdata;
        mfm_eo_pkg::CFG_DATA_WORD_COUNT: dwc_r  <= cfg_wdata[mfm_eo_pkg::WCNT_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    shift_nxt   = {shift_r[2*mfm_eo_pkg::WORD_W-2:0], raw_bit};
    bit_cnt_nxt = bit_cnt_r + 5'd1;
    word_done   = collecting_r && (bit_cnt_nxt == 5'd0);
    word        = mfm_eo_pkg::decode_even_odd(shift_nxt);
    dwc_ext     = CW'(dwc_r);
    limit       = (dwc_ext > WORD_CAP) ? WORD_CAP : dwc_ext;
    more_data   = CW'(word_cnt_r) < limit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r      <= '0;
      collecting_r <= 1'b0;
      bit_cnt_r    <= '0;
      word_cnt_r   <= '0;
      sum_r        <= '0;
    end else if (bit_accept) begin
      shift_r <= shift_nxt;
      if (!collecting_r) begin
        if (shift_nxt[mfm_eo_pkg::WORD_W-1:0] == sync_r) begin
          collecting_r <= 1'b1;
          bit_cnt_r    <= '0;
          word_cnt_r   <= '0;
          sum_r        <= '0;
        end
      end else begin
        bit_cnt_r <= bit_cnt_nxt;
        if (word_done) begin
          if (more_data) begin
            sum_r      <= sum_r + word;
            word_cnt_r <= word_cnt_r + WCW'(1);
          end else begin
            // checksum word closes the track, back to hunting
            collecting_r <= 1'b0;
            word_cnt_r   <= '0;
            sum_r        <= '0;
          end
        end
      end
    end
  end

  always_comb begin
    res.vld         = bit_accept && word_done;
    res.data_word   = word;
    res.last_word   = !more_data;
    res.checksum_ok = !more_data && (word == sum_r);
  end

endmodule

>>> src/mfm_eo_out.sv
// Output register for decoded words; gives the input side its ready.
// Depends on mfm_eo_pkg.
module mfm_eo_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mfm_eo_pkg::res_t              res,
  output logic                          load_ok,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mfm_eo_pkg::WORD_W-1:0] out_tdata,
  output logic                          out_tlast,
  output logic                          out_tuser
);

  logic                          vld_r;
  logic [mfm_eo_pkg::WORD_W-1:0] data_r;
  logic                          last_r;
  logic                          ok_r;

  // a new word may land only when the register is empty or draining
  assign load_ok = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res.vld) begin
      vld_r <= 1'b1;
    end else if (out_tready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.vld) begin
      data_r <= res.data_word;
      last_r <= res.last_word;
      ok_r   <= res.checksum_ok;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign out_tuser  = ok_r;

endmodule

>>> src/mfm_even_odd_track_deframer.sv
// Top level of the MFM even/odd track deframer: core, output register, checks.
// Depends on mfm_eo_pkg, mfm_eo_core, mfm_eo_out and the macros header.
//
// Takes one raw MFM bit per beat (in_tdata[0]) and accepts a bit every cycle
// while the output register is empty or being taken in the same cycle. After
// the 16 most recent bits equal sync_pattern, each following 32 bits yield one
// word, presented in the cycle after its 32nd bit is accepted: data_word_count
// data words (capped at MAX_WORDS-1) and then the checksum word with tlast set
// and tuser set if it equals the 16-bit wrapping sum of the data words. The
// block then hunts for sync again; sync is not searched while inside a track.
// The whole per-bit update is one pass through the counter and decode logic.
`include "mfm_even_odd_track_deframer_macros.svh"

module mfm_even_odd_track_deframer #(
  parameter int MAX_WORDS = mfm_eo_pkg::MAX_WORDS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [mfm_eo_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mfm_eo_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [0] raw_bit, [7:1] zero
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [mfm_eo_pkg::WORD_W-1:0]     out_tdata,  // [15:0] data_word
  output logic                              out_tlast,  // last_word
  output logic                              out_tuser   // checksum_ok
);

  mfm_eo_pkg::res_t res;
  logic             load_ok;
  logic             bit_accept;

  assign in_tready  = load_ok;
  assign bit_accept = in_tvalid && load_ok;

  mfm_eo_core #(
    .MAX_WORDS(MAX_WORDS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .bit_accept (bit_accept),
    .raw_bit    (in_tdata[0]),
    .res        (res)
  );

  mfm_eo_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .load_ok    (load_ok),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  `MFM_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_tvalid, in_tready)
  `MFM_ASSERT_NOW(a_word_needs_beat, clk, rst_n, res.vld, in_tvalid && in_tready)
  `MFM_ASSERT_NOW(a_ok_only_on_last, clk, rst_n, out_tvalid && out_tuser, out_tlast)
  `MFM_ASSERT_NEXT(a_word_shows, clk, rst_n, res.vld, out_tvalid)

endmodule
